### design/msrg_pkg.sv
// msrg_pkg: shared types and constants for the multi-stop row gradient
// used by msrg_div, msrg_ctrl, msrg_dp and multi_stop_row_gradient
package msrg_pkg;

  // field widths
  localparam int unsigned COORD_W = 16;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned STOP_W  = 39;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned CUR_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;

  // stop limits
  localparam int unsigned MAX_STOPS = 4;
  localparam int unsigned MIN_STOPS = 2;

  // shared serial divider sizing
  localparam int unsigned DIVIDEND_W = 24;
  localparam int unsigned DIVISOR_W  = 17;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned POS_STEPS  = 24;
  localparam int unsigned FRAC_STEPS = 8;

  // position scaling
  localparam int unsigned QPOS_W   = 9;
  localparam int unsigned QPOS_MAX = 256;
  localparam int unsigned PCT_SCALE = 100;

  // register reset values
  localparam logic [COORD_W-1:0] TOP_RST    = 16'd0;
  localparam logic [COORD_W-1:0] BOTTOM_RST = 16'd256;
  localparam logic [COUNT_W-1:0] COUNT_RST  = 3'd2;
  localparam logic [STOP_W-1:0]  STOP1_RST  = {7'd100, 32'd0};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOP    = 3'd0,
    CFG_BOTTOM = 3'd1,
    CFG_COUNT  = 3'd2,
    CFG_STOP0  = 3'd3,
    CFG_STOP1  = 3'd4,
    CFG_STOP2  = 3'd5,
    CFG_STOP3  = 3'd6
  } cfg_idx_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic prep;
    logic div_pos;
    logic pos_calc;
    logic check_err;
    logic step;
    logic commit;
    logic take_last;
    logic div_frac;
    logic blend;
    logic out_load;
  } msrg_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic span_bad;
    logic div_done;
    logic behind;
    logic more;
    logic at_last;
  } msrg_sts_t;

endpackage

### design/msrg_div.sv
// msrg_div: shared restoring divider, one quotient bit per cycle
// depends on msrg_pkg for widths
module msrg_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [msrg_pkg::DIVISOR_W-1:0]   init_rem,
  input  logic [msrg_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [msrg_pkg::DIVISOR_W-1:0]   divisor,
  input  logic [msrg_pkg::STEP_W-1:0]      steps,
  output logic                             done,
  output logic [msrg_pkg::DIVIDEND_W-1:0]  quotient
);
  import msrg_pkg::*;

  logic                   busy_r;
  logic                   done_r;
  logic [STEP_W-1:0]      cnt_r;
  logic [DIVISOR_W-1:0]   rem_r;
  logic [DIVISOR_W-1:0]   dvs_r;
  logic [DIVIDEND_W-1:0]  quo_r;
  logic [DIVISOR_W+1:0]   trial;

  // trial subtract of the divisor from the shifted remainder
  assign trial = {1'b0, rem_r, quo_r[DIVIDEND_W-1]} - {2'b00, dvs_r};

  // control: busy flag, step count, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= init_rem;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      if (trial[DIVISOR_W+1]) begin
        rem_r <= {rem_r[DIVISOR_W-2:0], quo_r[DIVIDEND_W-1]};
        quo_r <= {quo_r[DIVIDEND_W-2:0], 1'b0};
      end else begin
        rem_r <= trial[DIVISOR_W-1:0];
        quo_r <= {quo_r[DIVIDEND_W-2:0], 1'b1};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### design/msrg_dp.sv
// msrg_dp: configuration registers, stop cursor, position and blend datapath
// depends on msrg_pkg and instantiates msrg_div
module msrg_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  msrg_pkg::msrg_cmd_t               cmd,
  output msrg_pkg::msrg_sts_t               sts,
  input  logic                              cfg_valid,
  input  logic [msrg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msrg_pkg::STOP_W-1:0]       cfg_data,
  input  logic signed [msrg_pkg::COORD_W-1:0] in_row_y,
  input  logic                              in_restart_cursor,
  output logic [msrg_pkg::CHAN_W-1:0]       out_red,
  output logic [msrg_pkg::CHAN_W-1:0]       out_green,
  output logic [msrg_pkg::CHAN_W-1:0]       out_blue,
  output logic [msrg_pkg::CHAN_W-1:0]       out_alpha,
  output logic                              out_order_error
);
  import msrg_pkg::*;

  // configuration registers
  logic [COORD_W-1:0] top_r;
  logic [COORD_W-1:0] bottom_r;
  logic [COUNT_W-1:0] count_r;
  logic [STOP_W-1:0]  stop0_r, stop1_r, stop2_r, stop3_r;

  // per-item registers
  logic [COORD_W-1:0] y_r;
  logic               restart_r;
  logic [COORD_W:0]   span_r;
  logic               neg_r;
  logic [COORD_W-1:0] mag_r;
  logic [CUR_W-1:0]   cursor_r;
  logic [CUR_W-1:0]   i_r;
  logic [PCT_W-1:0]   pos_r;
  logic [COLOR_W-1:0] res_color_r;
  logic               res_err_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_err_r;

  logic [CUR_W-1:0]   last_idx;
  logic [CUR_W-1:0]   cur_clamp;
  logic [CUR_W-1:0]   i_next;
  logic [COORD_W:0]   span_nxt;
  logic [COORD_W:0]   diff_nxt;
  logic [COORD_W:0]   diff_abs;
  logic [STOP_W-1:0]  stop_a, stop_b;
  logic [PCT_W-1:0]   pct_a, pct_b;
  logic [QPOS_W-1:0]  q_pos;
  logic [15:0]        pos_prod;
  logic [DIVIDEND_W-1:0] quo;
  logic               div_done;
  logic               div_start;
  logic [DIVISOR_W-1:0]  div_init;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [STEP_W-1:0]     div_steps;
  logic [CHAN_W-1:0]     frac;
  logic [CHAN_W:0]       frac_inv;
  logic [COLOR_W-1:0]    blend_color;

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r    <= TOP_RST;
      bottom_r <= BOTTOM_RST;
      count_r  <= COUNT_RST;
      stop0_r  <= '0;
      stop1_r  <= STOP1_RST;
      stop2_r  <= '0;
      stop3_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TOP:    top_r    <= cfg_data[COORD_W-1:0];
        CFG_BOTTOM: bottom_r <= cfg_data[COORD_W-1:0];
        CFG_COUNT:  count_r  <= cfg_data[COUNT_W-1:0];
        CFG_STOP0:  stop0_r  <= cfg_data;
        CFG_STOP1:  stop1_r  <= cfg_data;
        CFG_STOP2:  stop2_r  <= cfg_data;
        CFG_STOP3:  stop3_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // index of the last stop in use
  always_comb begin
    if (count_r < COUNT_W'(MIN_STOPS)) begin
      last_idx = CUR_W'(MIN_STOPS - 1);
    end else if (count_r > COUNT_W'(MAX_STOPS)) begin
      last_idx = CUR_W'(MAX_STOPS - 1);
    end else begin
      last_idx = CUR_W'(count_r - COUNT_W'(1));
    end
  end

  // cursor after restart and clamp to the stops in use
  always_comb begin
    cur_clamp = restart_r ? '0 : cursor_r;
    if (cur_clamp > last_idx) begin
      cur_clamp = last_idx;
    end
  end

  // span and signed row offset
  assign span_nxt = {bottom_r[COORD_W-1], bottom_r} - {top_r[COORD_W-1], top_r};
  assign diff_nxt = {y_r[COORD_W-1], y_r} - {top_r[COORD_W-1], top_r};
  assign diff_abs = diff_nxt[COORD_W] ? (~diff_nxt + (COORD_W+1)'(1)) : diff_nxt;

  // stop selection at the search index and the one after it
  assign i_next = i_r + CUR_W'(1);
  always_comb begin
    case (i_r)
      2'd0:    stop_a = stop0_r;
      2'd1:    stop_a = stop1_r;
      2'd2:    stop_a = stop2_r;
      default: stop_a = stop3_r;
    endcase
    case (i_next)
      2'd0:    stop_b = stop0_r;
      2'd1:    stop_b = stop1_r;
      2'd2:    stop_b = stop2_r;
      default: stop_b = stop3_r;
    endcase
  end
  assign pct_a = stop_a[STOP_W-1:COLOR_W];
  assign pct_b = stop_b[STOP_W-1:COLOR_W];

  // clamped 9-bit position from the quotient, then percent
  always_comb begin
    if (span_r[COORD_W] || (span_r == '0)) begin
      q_pos = QPOS_W'(QPOS_MAX);
    end else if (neg_r) begin
      q_pos = (quo != '0) ? QPOS_W'(QPOS_MAX) : '0;
    end else if (quo > DIVIDEND_W'(QPOS_MAX)) begin
      q_pos = QPOS_W'(QPOS_MAX);
    end else begin
      q_pos = quo[QPOS_W-1:0];
    end
  end
  assign pos_prod = 16'(q_pos) * 16'(PCT_SCALE);

  // divider operand select: position or blend fraction
  assign div_start = cmd.div_pos | cmd.div_frac;
  always_comb begin
    if (cmd.div_frac) begin
      div_init     = DIVISOR_W'(pos_r - pct_a);
      div_dividend = '0;
      div_divisor  = DIVISOR_W'(pct_b - pct_a);
      div_steps    = STEP_W'(FRAC_STEPS);
    end else begin
      div_init     = '0;
      div_dividend = {mag_r, 8'd0};
      div_divisor  = span_r;
      div_steps    = STEP_W'(POS_STEPS);
    end
  end

  msrg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .init_rem (div_init),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (quo)
  );

  // per-channel blend of the two surrounding stops
  assign frac     = quo[CHAN_W-1:0];
  assign frac_inv = (CHAN_W+1)'(256) - {1'b0, frac};
  always_comb begin
    logic [16:0] sum;
    blend_color = '0;
    for (int c = 0; c < 4; c++) begin
      sum = 17'(stop_a[c*CHAN_W +: CHAN_W]) * 17'(frac_inv)
          + 17'(stop_b[c*CHAN_W +: CHAN_W]) * 17'(frac);
      blend_color[c*CHAN_W +: CHAN_W] = sum[15:8];
    end
  end

  // status to the controller
  assign sts.span_bad = span_r[COORD_W] || (span_r == '0);
  assign sts.div_done = div_done;
  assign sts.behind   = pos_r < pct_a;
  assign sts.more     = (i_r < last_idx) && (pos_r >= pct_b);
  assign sts.at_last  = i_r >= last_idx;

  // stop cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
    end else if (cmd.prep) begin
      cursor_r <= cur_clamp;
    end else if (cmd.commit) begin
      cursor_r <= i_r;
    end
  end

  // item, position and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      y_r       <= in_row_y;
      restart_r <= in_restart_cursor;
    end
    if (cmd.prep) begin
      span_r <= span_nxt;
      neg_r  <= diff_nxt[COORD_W];
      mag_r  <= diff_abs[COORD_W-1:0];
    end
    if (cmd.pos_calc) begin
      pos_r <= pos_prod[14:8];
      i_r   <= cursor_r;
    end else if (cmd.step) begin
      i_r <= i_next;
    end
    if (cmd.check_err) begin
      res_color_r <= stop_a[COLOR_W-1:0];
      res_err_r   <= 1'b1;
    end else if (cmd.take_last) begin
      res_color_r <= stop_a[COLOR_W-1:0];
      res_err_r   <= 1'b0;
    end else if (cmd.blend) begin
      res_color_r <= blend_color;
      res_err_r   <= 1'b0;
    end
    if (cmd.out_load) begin
      out_color_r <= res_color_r;
      out_err_r   <= res_err_r;
    end
  end

  assign out_red         = out_color_r[7:0];
  assign out_green       = out_color_r[15:8];
  assign out_blue        = out_color_r[23:16];
  assign out_alpha       = out_color_r[31:24];
  assign out_order_error = out_err_r;

endmodule

### design/msrg_ctrl.sv
// msrg_ctrl: sequencing state machine for one row item
// depends on msrg_pkg for command and status types
module msrg_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output msrg_pkg::msrg_cmd_t   cmd,
  input  msrg_pkg::msrg_sts_t   sts
);
  import msrg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIVP_START,
    S_DIVP,
    S_POS,
    S_CHECK,
    S_SEARCH,
    S_DIVF,
    S_BLEND,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_DIVP_START;
      end
      S_DIVP_START: begin
        if (sts.span_bad) begin
          state_nxt = S_POS;
        end else begin
          cmd.div_pos = 1'b1;
          state_nxt   = S_DIVP;
        end
      end
      S_DIVP: begin
        if (sts.div_done) begin
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        cmd.pos_calc = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_CHECK: begin
        if (sts.behind) begin
          cmd.check_err = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.more) begin
          cmd.step = 1'b1;
        end else begin
          cmd.commit = 1'b1;
          if (sts.at_last) begin
            cmd.take_last = 1'b1;
            state_nxt     = S_DONE;
          end else begin
            cmd.div_frac = 1'b1;
            state_nxt    = S_DIVF;
          end
        end
      end
      S_DIVF: begin
        if (sts.div_done) begin
          state_nxt = S_BLEND;
        end
      end
      S_BLEND: begin
        cmd.blend = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### design/multi_stop_row_gradient.sv
// multi_stop_row_gradient: top level of the vertical multi-stop gradient
// depends on msrg_pkg, msrg_ctrl, msrg_dp (which holds msrg_div)
//
//   channel | ports                                 | handshake
//   input   | in_row_y, in_restart_cursor           | in_valid / in_stall
//   result  | out_red/green/blue/alpha, out_order_error | out_valid / out_stall
//   config  | cfg_index, cfg_data                   | cfg_valid / cfg_ready
//
// a row goes through the shared serial divider for the position when the span is
// positive, then a stop search, and the divider again for the blend fraction when
// the row is blended between two stops; an idle state lies between rows.
// synchronous active-low reset restores the register defaults and cursor 0.
// a finished result waits in the output register while the next row is taken.
module multi_stop_row_gradient (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [msrg_pkg::COORD_W-1:0] in_row_y,
  input  logic                                in_restart_cursor,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [msrg_pkg::CHAN_W-1:0]         out_red,
  output logic [msrg_pkg::CHAN_W-1:0]         out_green,
  output logic [msrg_pkg::CHAN_W-1:0]         out_blue,
  output logic [msrg_pkg::CHAN_W-1:0]         out_alpha,
  output logic                                out_order_error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [msrg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [msrg_pkg::STOP_W-1:0]         cfg_data
);
  import msrg_pkg::*;

  msrg_cmd_t cmd;
  msrg_sts_t sts;

  // config writes are to land while idle, a rule the block does not enforce; the port is always open
  assign cfg_ready = 1'b1;

  msrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  msrg_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_valid         (cfg_valid & cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_row_y          (in_row_y),
    .in_restart_cursor (in_restart_cursor),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_alpha         (out_alpha),
    .out_order_error   (out_order_error)
  );

endmodule

### tb/multi_stop_row_gradient_tb.sv
// multi_stop_row_gradient_tb: self-checking bench for the vertical multi-stop row gradient
// holds its own row shade model in a small class and drives the row, result and register ports
// depends on msrg_pkg and multi_stop_row_gradient
module multi_stop_row_gradient_tb;
  import msrg_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 5;
  localparam int RANDOM_ROWS     = 700;
  localparam int QUIET_ROWS      = 150;
  localparam int LONG_HOLD       = 300;
  localparam int TAIL_CYCLES     = 64;
  localparam int WATCHDOG_CYCLES = 4000;

  // one row color as the block reports it
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       order_error;
  } row_shade_t;

  // tracks gradient registers and the stop cursor, predicts and checks row shades
  class row_shade_tracker;
    logic signed [15:0] grad_top;
    logic signed [15:0] grad_bottom;
    logic [2:0]         stop_cnt;
    logic [38:0]        stop_reg [4];
    int                 cursor;
    row_shade_t         shades_due [$];
    int                 errors;

    function new();
      grad_top    = 16'sd0;
      grad_bottom = 16'sd256;
      stop_cnt    = 3'd2;
      stop_reg[0] = '0;
      stop_reg[1] = {7'd100, 32'd0};
      stop_reg[2] = '0;
      stop_reg[3] = '0;
      cursor      = 0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [38:0] data);
      case (idx)
        CFG_TOP:    grad_top    = data[15:0];
        CFG_BOTTOM: grad_bottom = data[15:0];
        CFG_COUNT:  stop_cnt    = data[2:0];
        CFG_STOP0:  stop_reg[0] = data;
        CFG_STOP1:  stop_reg[1] = data;
        CFG_STOP2:  stop_reg[2] = data;
        CFG_STOP3:  stop_reg[3] = data;
        default: ;
      endcase
    endfunction

    function int pct(int i);
      return stop_reg[i][38:32];
    endfunction

    function int chan(int i, int ch);
      return stop_reg[i][8*ch +: 8];
    endfunction

    // position from the row, cursor walk, then last stop color or a blend
    function row_shade_t shade_row(logic signed [15:0] y, logic restart);
      int         n, yi, ti, span, q, pos, i, f, ch, lo, hi;
      logic [7:0] chans [4];
      logic       behind;
      n = stop_cnt;
      if (n < 2) n = 2;
      if (n > MAX_STOPS) n = MAX_STOPS;
      if (restart) cursor = 0;
      if (cursor >= n) cursor = n - 1;
      yi   = y;
      ti   = grad_top;
      span = int'(grad_bottom) - ti;
      if (span <= 0) begin
        q = 256;
      end else begin
        q = ((yi - ti) * 256) / span;
        if (q < 0 || q > 256) q = 256;
      end
      pos    = (q * 100) >> 8;
      i      = cursor;
      behind = 1'b0;
      if (pos < pct(i)) begin
        // behind the cursor stop: its color, cursor kept
        behind = 1'b1;
        for (ch = 0; ch < 4; ch++) chans[ch] = 8'(chan(i, ch));
      end else begin
        while (i < n - 1 && pos >= pct(i + 1)) i++;
        if (i >= n - 1) begin
          for (ch = 0; ch < 4; ch++) chans[ch] = 8'(chan(i, ch));
        end else begin
          lo = pct(i);
          hi = pct(i + 1);
          f  = ((pos - lo) << 8) / (hi - lo);
          for (ch = 0; ch < 4; ch++)
            chans[ch] = 8'((chan(i, ch) * (256 - f) + chan(i + 1, ch) * f) >> 8);
        end
        cursor = i;
      end
      return '{red: chans[0], green: chans[1], blue: chans[2], alpha: chans[3],
               order_error: behind};
    endfunction

    function void note_row(logic signed [15:0] y, logic restart);
      shades_due.push_back(shade_row(y, restart));
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_shade(row_shade_t got);
      row_shade_t want;
      if (shades_due.size() == 0) begin
        $display("%0t: row color with no row waiting, actual %h", $time, got);
        errors++;
        return;
      end
      want = shades_due.pop_front();
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha", want.alpha, got.alpha);
      compare_field("order_error", want.order_error, got.order_error);
    endfunction

    function int pending();
      return shades_due.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic signed [15:0]  in_row_y;
  logic                in_restart_cursor;
  logic                out_valid;
  logic                out_stall;
  logic [7:0]          out_red;
  logic [7:0]          out_green;
  logic [7:0]          out_blue;
  logic [7:0]          out_alpha;
  logic                out_order_error;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [STOP_W-1:0]   cfg_data;

  row_shade_tracker shades = new();

  bit tx_gaps;
  bit rx_gaps;
  bit hold_off;
  int rows_sent;
  int quiet_cycles;

  multi_stop_row_gradient DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_row_y          (in_row_y),
    .in_restart_cursor (in_restart_cursor),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_alpha         (out_alpha),
    .out_order_error   (out_order_error),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) shades.set_reg(cfg_idx_t'(cfg_index), cfg_data);
      if (in_valid && !in_stall) shades.note_row(in_row_y, in_restart_cursor);
      if (out_valid && !out_stall)
        shades.check_shade({out_red, out_green, out_blue, out_alpha, out_order_error});
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_CYCLES);
        $display("multi_stop_row_gradient: mismatch");
        $finish;
      end
    end
  end

  // result side: random stall bursts, or one long hold when asked
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // one row transaction, with an optional idle burst ahead of it
  task automatic send_row(logic signed [15:0] y, logic restart);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_row_y          <= y;
    in_restart_cursor <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rows_sent++;
  endtask

  // stop offering rows and wait for every row color to come back
  task automatic wait_shades();
    in_valid <= 1'b0;
    do @(posedge clk); while (shades.pending() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [38:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_setting(logic [15:0] top, logic [15:0] bottom, logic [2:0] cnt,
                              logic [38:0] s0, logic [38:0] s1, logic [38:0] s2,
                              logic [38:0] s3);
    write_reg(CFG_TOP, {23'd0, top});
    write_reg(CFG_BOTTOM, {23'd0, bottom});
    write_reg(CFG_COUNT, {36'd0, cnt});
    write_reg(CFG_STOP0, s0);
    write_reg(CFG_STOP1, s1);
    write_reg(CFG_STOP2, s2);
    write_reg(CFG_STOP3, s3);
    cfg_valid <= 1'b0;
  endtask

  // tidy settings have a positive span and rising stop percents
  task automatic load_random_setting(bit tidy, output int t, output int b);
    int          span, k, p;
    int          pcts [4];
    logic [38:0] s [4];
    logic [2:0]  cnt;
    if (tidy) begin
      case ($urandom_range(0, 3))
        0:       span = $urandom_range(1, 64);
        1:       span = $urandom_range(65, 2000);
        2:       span = $urandom_range(2001, 65535);
        default: span = $urandom_range(1, 400);
      endcase
      t   = $urandom_range(0, 65535 - span);
      t   = t - 32768;
      b   = t + span;
      cnt = 3'($urandom_range(2, 4));
      p   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 0;
      for (k = 0; k < 4; k++) begin
        if (k > 0) p = p + $urandom_range(0, 50);
        if (p > 127) p = 127;
        pcts[k] = p;
      end
    end else begin
      t   = $urandom_range(0, 65535);
      t   = t - 32768;
      b   = $urandom_range(0, 65535);
      b   = b - 32768;
      cnt = 3'($urandom_range(0, 7));
      for (k = 0; k < 4; k++) pcts[k] = $urandom_range(0, 127);
    end
    for (k = 0; k < 4; k++) s[k] = {pcts[k][6:0], 32'($urandom)};
    load_setting(t[15:0], b[15:0], cnt, s[0], s[1], s[2], s[3]);
  endtask

  // a frame: restart, then rows rising through the span and a bit past it
  task automatic send_sweep(int t, int b);
    int y, span, stride, step, rows;
    span   = (b > t) ? b - t : 400;
    stride = span / $urandom_range(4, 24);
    if (stride < 1) stride = 1;
    step = $urandom_range(0, 2 * stride);
    y    = t - step;
    if (y < -32768) y = -32768;
    send_row(y[15:0], 1'b1);
    rows = 1;
    while (rows < 40 && y < b + stride) begin
      step = $urandom_range(1, stride);
      y    = y + step;
      if (y > 32767) break;
      send_row(y[15:0], $urandom_range(0, 15) == 0);
      rows++;
    end
  endtask

  task automatic send_noise(int n);
    repeat (n) send_row(16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int  t, b, first_random;
    bit  late;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_row_y          <= '0;
    in_restart_cursor <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_index         <= CFG_TOP;
    cfg_data          <= '0;
    tx_gaps  = 1'b1;
    rx_gaps  = 1'b1;
    hold_off = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: negative quotient, mid span, quotient above range
    send_row(-16'sd32768, 1'b1);
    send_row(16'sd128, 1'b1);
    send_row(16'sd32767, 1'b0);
    wait_shades();

    // widest span, four stops, then a row behind the cursor stop
    load_setting(16'h8000, 16'h7fff, 3'd4, {7'd0, 32'h00000000}, {7'd33, 32'hff00ff00},
                 {7'd66, 32'h00ff00ff}, {7'd100, 32'hffffffff});
    send_row(-16'sd32768, 1'b1);
    send_row(-16'sd16384, 1'b0);
    send_row(16'sd0, 1'b0);
    send_row(16'sd16384, 1'b0);
    send_row(16'sd32767, 1'b0);
    send_row(-16'sd32768, 1'b0);
    wait_shades();

    // zero span, and cursor beyond the two stops now in use
    load_setting(16'd100, 16'd100, 3'd2, {7'd0, 32'h12345678}, {7'd100, 32'h87654321},
                 '0, '0);
    send_row(16'sd50, 1'b0);
    wait_shades();

    // negative span, stop count below the minimum
    load_setting(16'h7fff, 16'h8000, 3'd0, {7'd0, 32'hffffffff}, {7'd100, 32'h0f0f0f0f},
                 '0, '0);
    send_row(16'sd0, 1'b1);
    wait_shades();

    // stop count above the maximum, last stop percent out of reach
    load_setting(16'd0, 16'd1, 3'd7, {7'd0, 32'hc0ffee00}, {7'd50, 32'h00aa5501},
                 {7'd100, 32'h7f80ff00}, '1);
    send_row(16'sd0, 1'b1);
    send_row(16'sd1, 1'b0);
    send_row(-16'sd1, 1'b0);
    wait_shades();

    // stop count of one, first stop above zero
    load_setting(16'd0, 16'd255, 3'd1, {7'd10, 32'h11223344}, {7'd90, 32'hfedcba98},
                 '0, '0);
    send_row(16'sd0, 1'b1);
    send_row(16'sd128, 1'b0);
    send_row(16'sd255, 1'b0);
    wait_shades();

    // long result hold while rows keep coming, so the block backs up
    tx_gaps = 1'b0;
    load_random_setting(1'b1, t, b);
    hold_off = 1'b1;
    send_sweep(t, b);
    send_sweep(t, b);

    // random settings, mostly tidy frames with some noise
    first_random = rows_sent;
    while (rows_sent - first_random < RANDOM_ROWS) begin
      wait_shades();
      late    = (rows_sent - first_random) > (RANDOM_ROWS - QUIET_ROWS);
      tx_gaps = !late && $urandom_range(0, 3) != 0;
      rx_gaps = !late && $urandom_range(0, 3) != 0;
      load_random_setting($urandom_range(0, 4) != 0, t, b);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0)
          send_noise($urandom_range(3, 10));
        else
          send_sweep(t, b);
      end
    end

    wait_shades();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shades.errors == 0 && shades.pending() == 0)
      $display("multi_stop_row_gradient: match");
    else
      $display("multi_stop_row_gradient: mismatch");
    $finish;
  end

endmodule

### multi_stop_row_gradient.f
design/msrg_pkg.sv
design/msrg_div.sv
design/msrg_dp.sv
design/msrg_ctrl.sv
design/multi_stop_row_gradient.sv
tb/multi_stop_row_gradient_tb.sv
